@@ hdl/dpce_pkg.sv @@
// types and constants shared by the difference prefix code encoder
package dpce_pkg;

  typedef struct packed {
    logic signed [8:0] diff;
    logic              last;
  } diff_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } code_item_t;

  // magnitude class bounds and offsets
  localparam logic [8:0] CLASS1_BASE = 9'd2;
  localparam logic [8:0] CLASS2_BASE = 9'd6;
  localparam logic [8:0] CLASS3_BASE = 9'd22;

  // class prefixes
  localparam logic [1:0] PREFIX1 = 2'b10;
  localparam logic [2:0] PREFIX2 = 3'b110;
  localparam logic [2:0] PREFIX3 = 3'b111;

  // total code lengths per class
  localparam logic [3:0] LEN0 = 4'd3;
  localparam logic [3:0] LEN1 = 4'd5;
  localparam logic [3:0] LEN2 = 4'd8;
  localparam logic [3:0] LEN3 = 4'd12;

  // packed code bits, left aligned, are placed into this many bits
  localparam logic [4:0] ALIGN_BITS = 5'd24;

endpackage

@@ hdl/difference_prefix_code_encoder_unit.sv @@
// top level of the difference prefix code encoder
//
// request channel: diff_valid / diff_stall / diff_item carry one signed difference
// and a last flag. result channel: code_valid / code_stall / code_item carry one
// packed code byte, first code bit in the msb, and last_byte on the final byte
// of a stream.
// each difference becomes a 3 to 12 bit code that is packed behind the bits left
// over from earlier requests. a request yields zero, one, two or three bytes; on
// last the partial byte is flushed zero padded and the packer starts fresh.
// with the byte register empty, a request moves from the input register into the
// byte group register, where its first byte is shown and can be taken.
// throughput: the byte output register drains one byte per cycle while code_stall
// is low; the next request is taken into the input register while the current
// bytes are still draining.
// reset clears both valid flags and the leftover bits.
// a stalled result holds its byte; the input register then fills and diff_stall
// rises until the result side takes the final byte of the group.
module difference_prefix_code_encoder_unit
  import dpce_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       diff_valid,
  output logic       diff_stall,
  input  diff_item_t diff_item,
  output logic       code_valid,
  input  logic       code_stall,
  output code_item_t code_item
);

  // input register
  logic       a_valid;
  diff_item_t a_item;

  // leftover code bits
  logic [6:0] pending_bits;
  logic [2:0] pending_count;

  // byte group register
  logic [7:0] g_bytes [3];
  logic [1:0] g_count;
  logic [1:0] g_idx;
  logic       g_last;

  logic        neg;
  logic [8:0]  mag;
  logic [8:0]  rel1, rel2, rel3;
  logic [11:0] code;
  logic [3:0]  len;
  logic [18:0] acc;
  logic [4:0]  n;
  logic [23:0] aligned;
  logic [2:0]  rem;
  logic [6:0]  keep_mask;
  logic        flush;
  logic [1:0]  new_count;
  logic        g_final;
  logic        out_take;
  logic        a_move;
  logic        in_take;

  always_comb begin
    neg  = a_item.diff[8];
    mag  = neg ? (9'd0 - a_item.diff) : a_item.diff;
    rel1 = mag - CLASS1_BASE;
    rel2 = mag - CLASS2_BASE;
    rel3 = mag - CLASS3_BASE;
    if (mag < CLASS1_BASE) begin
      code = {9'd0, 1'b0, mag[0], neg};
      len  = LEN0;
    end else if (mag < CLASS2_BASE) begin
      code = {7'd0, PREFIX1, rel1[1:0], neg};
      len  = LEN1;
    end else if (mag < CLASS3_BASE) begin
      code = {4'd0, PREFIX2, rel2[3:0], neg};
      len  = LEN2;
    end else begin
      code = {PREFIX3, rel3[7:0], neg};
      len  = LEN3;
    end
    acc       = ({12'd0, pending_bits} << len) | {7'd0, code};
    n         = {2'd0, pending_count} + {1'b0, len};
    aligned   = {5'd0, acc} << (ALIGN_BITS - n);
    rem       = n[2:0];
    keep_mask = ~(7'h7f << rem);
    flush     = a_item.last && (rem != 3'd0);
    new_count = n[4:3] + {1'b0, flush};
  end

  always_comb begin
    code_valid = (g_count != 2'd0);
    g_final    = (g_idx == g_count - 2'd1);
    out_take   = code_valid && !code_stall;
    a_move     = a_valid && (!code_valid || (out_take && g_final));
    diff_stall = a_valid && !a_move;
    in_take    = diff_valid && !diff_stall;
    unique case (g_idx)
      2'd0:    code_item.out_byte = g_bytes[0];
      2'd1:    code_item.out_byte = g_bytes[1];
      default: code_item.out_byte = g_bytes[2];
    endcase
    code_item.last_byte = g_last && g_final;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_take) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
    if (in_take) begin
      a_item <= diff_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= 7'd0;
      pending_count <= 3'd0;
    end else if (a_move) begin
      if (a_item.last) begin
        pending_bits  <= 7'd0;
        pending_count <= 3'd0;
      end else begin
        pending_bits  <= acc[6:0] & keep_mask;
        pending_count <= rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_count <= 2'd0;
      g_idx   <= 2'd0;
    end else if (a_move) begin
      g_count <= new_count;
      g_idx   <= 2'd0;
    end else if (out_take) begin
      if (g_final) begin
        g_count <= 2'd0;
        g_idx   <= 2'd0;
      end else begin
        g_idx <= g_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      g_bytes[0] <= aligned[23:16];
      g_bytes[1] <= aligned[15:8];
      g_bytes[2] <= aligned[7:0];
      g_last     <= a_item.last;
    end
  end

endmodule

@@ hdl/dpce_checker.sv @@
// port level checker for the difference prefix code encoder, with its bind
module dpce_checker
  import dpce_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       diff_valid,
  input logic       diff_stall,
  input diff_item_t diff_item,
  input logic       code_valid,
  input logic       code_stall,
  input code_item_t code_item
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    code_valid && code_stall |=> code_valid && $stable(code_item))
    else $error("stalled result changed");

  // both sides come out of reset empty
  assert property (@(posedge clk) rst |=> !code_valid && !diff_stall)
    else $error("not empty after reset");

  // requests are held back only while a result is waiting
  assert property (@(posedge clk) disable iff (rst) diff_stall |-> code_valid)
    else $error("request stalled with no result pending");

endmodule

bind difference_prefix_code_encoder_unit dpce_checker u_dpce_checker (.*);
